FILE: src/qpu_pkg.sv
`default_nettype none

package qpu_pkg;

  localparam int DataW = 32;
  localparam int AccW = 64;

  typedef logic [2:0] opcode_t;

  localparam opcode_t OP_LOAD = 3'd0;
  localparam opcode_t OP_COMPOSE = 3'd1;
  localparam opcode_t OP_XFORM = 3'd2;
  localparam opcode_t OP_ROTATE = 3'd3;
  localparam opcode_t OP_INVERT = 3'd4;
  localparam opcode_t OP_READ = 3'd5;
  localparam opcode_t OP_COMPARE = 3'd6;

  typedef logic [1:0] phase_t;

  localparam phase_t PH_QMUL = 2'd0;
  localparam phase_t PH_NORM = 2'd1;
  localparam phase_t PH_MAT = 2'd2;
  localparam phase_t PH_ROW = 2'd3;

  typedef struct packed {
    logic [3:0] ai;
    logic [1:0] bi;
    logic       neg;
    logic       dbl;
    logic       last;
    logic [3:0] dst;
  } uop_t;

  function automatic uop_t mk(int a, int b, logic n, logic d, logic l, int t);
    uop_t u;
    u.ai = 4'(a);
    u.bi = 2'(b);
    u.neg = n;
    u.dbl = d;
    u.last = l;
    u.dst = 4'(t);
    return u;
  endfunction

  function automatic logic [4:0] f_len(phase_t ph);
    logic [4:0] n;
    unique case (ph)
      PH_QMUL: n = 5'd16;
      PH_NORM: n = 5'd4;
      PH_MAT:  n = 5'd24;
      default: n = 5'd9;
    endcase
    return n;
  endfunction

  // Quaternion components are indexed x, y, z, w.
  function automatic uop_t f_uop(phase_t ph, logic [4:0] k);
    uop_t u;
    u = mk(0, 0, 1'b0, 1'b0, 1'b1, 0);
    unique case (ph)
      PH_QMUL: begin
        unique case (k)
          5'd0:  u = mk(0, 3, 1'b0, 1'b0, 1'b0, 0);
          5'd1:  u = mk(3, 0, 1'b0, 1'b0, 1'b0, 0);
          5'd2:  u = mk(1, 2, 1'b0, 1'b0, 1'b0, 0);
          5'd3:  u = mk(2, 1, 1'b1, 1'b0, 1'b1, 0);
          5'd4:  u = mk(1, 3, 1'b0, 1'b0, 1'b0, 1);
          5'd5:  u = mk(3, 1, 1'b0, 1'b0, 1'b0, 1);
          5'd6:  u = mk(2, 0, 1'b0, 1'b0, 1'b0, 1);
          5'd7:  u = mk(0, 2, 1'b1, 1'b0, 1'b1, 1);
          5'd8:  u = mk(2, 3, 1'b0, 1'b0, 1'b0, 2);
          5'd9:  u = mk(3, 2, 1'b0, 1'b0, 1'b0, 2);
          5'd10: u = mk(0, 1, 1'b0, 1'b0, 1'b0, 2);
          5'd11: u = mk(1, 0, 1'b1, 1'b0, 1'b1, 2);
          5'd12: u = mk(3, 3, 1'b0, 1'b0, 1'b0, 3);
          5'd13: u = mk(0, 0, 1'b1, 1'b0, 1'b0, 3);
          5'd14: u = mk(1, 1, 1'b1, 1'b0, 1'b0, 3);
          5'd15: u = mk(2, 2, 1'b1, 1'b0, 1'b1, 3);
          default: u = mk(0, 0, 1'b0, 1'b0, 1'b1, 0);
        endcase
      end
      PH_NORM: begin
        u = mk(int'(k[1:0]), int'(k[1:0]), 1'b0, 1'b0, k[1:0] == 2'd3, 0);
      end
      PH_MAT: begin
        unique case (k)
          5'd0:  u = mk(3, 3, 1'b0, 1'b0, 1'b0, 0);
          5'd1:  u = mk(0, 0, 1'b0, 1'b0, 1'b0, 0);
          5'd2:  u = mk(1, 1, 1'b1, 1'b0, 1'b0, 0);
          5'd3:  u = mk(2, 2, 1'b1, 1'b0, 1'b1, 0);
          5'd4:  u = mk(3, 3, 1'b0, 1'b0, 1'b0, 4);
          5'd5:  u = mk(0, 0, 1'b1, 1'b0, 1'b0, 4);
          5'd6:  u = mk(1, 1, 1'b0, 1'b0, 1'b0, 4);
          5'd7:  u = mk(2, 2, 1'b1, 1'b0, 1'b1, 4);
          5'd8:  u = mk(3, 3, 1'b0, 1'b0, 1'b0, 8);
          5'd9:  u = mk(0, 0, 1'b1, 1'b0, 1'b0, 8);
          5'd10: u = mk(1, 1, 1'b1, 1'b0, 1'b0, 8);
          5'd11: u = mk(2, 2, 1'b0, 1'b0, 1'b1, 8);
          5'd12: u = mk(0, 1, 1'b0, 1'b1, 1'b0, 3);
          5'd13: u = mk(2, 3, 1'b0, 1'b1, 1'b1, 3);
          5'd14: u = mk(2, 0, 1'b0, 1'b1, 1'b0, 6);
          5'd15: u = mk(1, 3, 1'b1, 1'b1, 1'b1, 6);
          5'd16: u = mk(0, 1, 1'b0, 1'b1, 1'b0, 1);
          5'd17: u = mk(2, 3, 1'b1, 1'b1, 1'b1, 1);
          5'd18: u = mk(1, 2, 1'b0, 1'b1, 1'b0, 7);
          5'd19: u = mk(0, 3, 1'b0, 1'b1, 1'b1, 7);
          5'd20: u = mk(2, 0, 1'b0, 1'b1, 1'b0, 2);
          5'd21: u = mk(1, 3, 1'b0, 1'b1, 1'b1, 2);
          5'd22: u = mk(1, 2, 1'b0, 1'b1, 1'b0, 5);
          5'd23: u = mk(0, 3, 1'b1, 1'b1, 1'b1, 5);
          default: u = mk(0, 0, 1'b0, 1'b0, 1'b1, 0);
        endcase
      end
      default: begin
        unique case (k)
          5'd0: u = mk(0, 0, 1'b0, 1'b0, 1'b0, 0);
          5'd1: u = mk(1, 1, 1'b0, 1'b0, 1'b0, 0);
          5'd2: u = mk(2, 2, 1'b0, 1'b0, 1'b1, 0);
          5'd3: u = mk(3, 0, 1'b0, 1'b0, 1'b0, 1);
          5'd4: u = mk(4, 1, 1'b0, 1'b0, 1'b0, 1);
          5'd5: u = mk(5, 2, 1'b0, 1'b0, 1'b1, 1);
          5'd6: u = mk(6, 0, 1'b0, 1'b0, 1'b0, 2);
          5'd7: u = mk(7, 1, 1'b0, 1'b0, 1'b0, 2);
          5'd8: u = mk(8, 2, 1'b0, 1'b0, 1'b1, 2);
          default: u = mk(0, 0, 1'b0, 1'b0, 1'b1, 0);
        endcase
      end
    endcase
    return u;
  endfunction

  function automatic logic signed [DataW-1:0] f_sat(logic signed [AccW-1:0] v);
    logic signed [DataW-1:0] r;
    if (v > 64'sh7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

  function automatic logic f_ovf(logic signed [AccW-1:0] v);
    return (v > 64'sh7FFF_FFFF) || (v < -64'sh8000_0000);
  endfunction

endpackage

`default_nettype wire

FILE: src/qpu_if.sv
`default_nettype none

interface qpu_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [31:0] quat_w;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;

  modport source (
    output valid, opcode, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    input ready
  );
  modport sink (
    input valid, opcode, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    output ready
  );
endinterface

interface qpu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_w;
  logic signed [31:0] out_qx;
  logic signed [31:0] out_qy;
  logic signed [31:0] out_qz;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               equal_flag;
  logic               overflow_flag;

  modport source (
    output valid, out_w, out_qx, out_qy, out_qz, out_x, out_y, out_z, equal_flag,
    overflow_flag,
    input ready
  );
  modport sink (
    input valid, out_w, out_qx, out_qy, out_qz, out_x, out_y, out_z, equal_flag,
    overflow_flag,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/qpu_div.sv
`default_nettype none

module qpu_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [63:0] den_i,
  output logic             done_o,
  output logic [63:0]      quo_o
);

  logic [63:0] rem_q;
  logic [63:0] quo_q;
  logic [63:0] den_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [64:0] rs;
  logic        ge;

  assign rs = {rem_q, quo_q[63]};
  assign ge = rs >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      quo_q <= '0;
      den_q <= '0;
      cnt_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q <= '0;
        quo_q <= num_i;
        den_q <= den_i;
        cnt_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? 64'(rs - {1'b0, den_q}) : rs[63:0];
        quo_q <= {quo_q[62:0], ge};
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o = quo_q;

endmodule

`default_nettype wire

FILE: src/quaternion_pose_unit.sv
// Load, read and compare go straight to the done state, which registers the result.
// Transform, rotate, compose and invert share one 32x32 multiplier: each product term
// passes through a multiply state and an accumulate state, and the inverse divides
// each component in a restoring divider.
// One word is processed at a time; input is ready again once the result is registered.
// Reset loads the identity pose and empties the output register.
`default_nettype none

module quaternion_pose_unit #(
  parameter int QUAT_FRAC_BITS = 30
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  qpu_in_if.sink      in_i,
  qpu_out_if.source   out_o
);

  localparam int Sh = QUAT_FRAC_BITS - 2;
  localparam logic signed [63:0] RndHalf = 64'sd1 <<< (Sh - 1);
  localparam logic signed [31:0] QuatOne = 32'sd1 <<< QUAT_FRAC_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]          st_q;
  qpu_pkg::phase_t     ph_q;
  logic [4:0]          k_q;
  logic [1:0]          di_q;
  qpu_pkg::opcode_t    op_q;
  qpu_pkg::uop_t       cu_q;
  logic                ovf_q, eq_q, cm_q, rneg_q, dstart_q, ov_q;
  logic signed [31:0]  hq_q [4];
  logic signed [31:0]  ht_q [3];
  logic signed [31:0]  pq_q [4];
  logic signed [31:0]  rq_q [4];
  logic signed [31:0]  rv_q [3];
  logic signed [31:0]  ra_q [3];
  logic signed [31:0]  wq_q [4];
  logic signed [31:0]  m_q [9];
  logic signed [31:0]  res_q [3];
  logic signed [63:0]  p_q, acc_q, d_q;
  logic signed [31:0]  ow_q, oqx_q, oqy_q, oqz_q, ox_q, oy_q, oz_q;
  logic                oeq_q, oovf_q;

  qpu_pkg::uop_t       uop;
  logic signed [31:0]  a_op, b_op;
  logic signed [63:0]  tsh, term, acc_n, rnd, fv;
  logic signed [31:0]  fsat, qsat;
  logic                fovf, qovf, vec_res, out_free;
  logic signed [32:0]  cext, cval;
  logic [32:0]         mag;
  logic [63:0]         num, quo;
  logic signed [63:0]  sq;
  logic                div_done;

  assign uop = qpu_pkg::f_uop(ph_q, k_q);

  always_comb begin
    unique case (ph_q)
      qpu_pkg::PH_QMUL: begin
        a_op = hq_q[uop.ai[1:0]];
        b_op = pq_q[uop.bi];
      end
      qpu_pkg::PH_NORM: begin
        a_op = hq_q[uop.ai[1:0]];
        b_op = hq_q[uop.bi];
      end
      qpu_pkg::PH_MAT: begin
        a_op = rq_q[uop.ai[1:0]];
        b_op = rq_q[uop.bi];
      end
      default: begin
        a_op = m_q[uop.ai];
        b_op = rv_q[uop.bi];
      end
    endcase
  end

  assign tsh = p_q >>> 2;
  assign term = cu_q.dbl ? (tsh <<< 1) : tsh;
  assign acc_n = cu_q.neg ? acc_q - term : acc_q + term;

  always_comb begin
    rnd = (acc_q + RndHalf) >>> Sh;
    fv = rnd;
    if (ph_q == qpu_pkg::PH_ROW) begin
      fv = (rneg_q ? -rnd : rnd) + 64'(ra_q[cu_q.dst[1:0]]);
    end
  end

  assign fsat = qpu_pkg::f_sat(fv);
  assign fovf = qpu_pkg::f_ovf(fv);

  assign cext = 33'(hq_q[di_q]);
  assign cval = (di_q != 2'd3) ? -cext : cext;
  assign mag = cval[32] ? 33'(-cval) : 33'(cval);
  assign num = (64'(mag) << QUAT_FRAC_BITS) + (d_q >> 1);
  assign sq = cval[32] ? -$signed(quo) : $signed(quo);
  assign qsat = qpu_pkg::f_sat(sq);
  assign qovf = qpu_pkg::f_ovf(sq);

  qpu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dstart_q),
    .num_i   (num),
    .den_i   (d_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign vec_res = (op_q == qpu_pkg::OP_XFORM) || (op_q == qpu_pkg::OP_ROTATE);
  assign out_free = !ov_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ph_q <= qpu_pkg::PH_QMUL;
      k_q <= '0;
      di_q <= '0;
      op_q <= qpu_pkg::OP_READ;
      cu_q <= '0;
      ovf_q <= 1'b0;
      eq_q <= 1'b0;
      cm_q <= 1'b0;
      rneg_q <= 1'b0;
      dstart_q <= 1'b0;
      ov_q <= 1'b0;
      p_q <= '0;
      acc_q <= '0;
      d_q <= '0;
      for (int i = 0; i < 4; i++) begin
        hq_q[i] <= (i == 3) ? QuatOne : 32'sd0;
        rq_q[i] <= '0;
        wq_q[i] <= '0;
        pq_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        ht_q[i] <= '0;
        rv_q[i] <= '0;
        ra_q[i] <= '0;
        res_q[i] <= '0;
      end
      for (int i = 0; i < 9; i++) begin
        m_q[i] <= '0;
      end
      ow_q <= '0;
      oqx_q <= '0;
      oqy_q <= '0;
      oqz_q <= '0;
      ox_q <= '0;
      oy_q <= '0;
      oz_q <= '0;
      oeq_q <= 1'b0;
      oovf_q <= 1'b0;
    end else begin
      dstart_q <= ((st_q == S_FIN) && (ph_q == qpu_pkg::PH_NORM) &&
                   (k_q == qpu_pkg::f_len(ph_q)) && (rnd > 64'sd0)) ||
                  ((st_q == S_DIV) && div_done && (di_q != 2'd3));
      if ((st_q == S_DONE) && out_free) begin
        ov_q <= 1'b1;
      end else if (ov_q && out_o.ready) begin
        ov_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: begin
          if (in_i.valid) begin
            op_q <= in_i.opcode;
            pq_q[0] <= in_i.quat_x;
            pq_q[1] <= in_i.quat_y;
            pq_q[2] <= in_i.quat_z;
            pq_q[3] <= in_i.quat_w;
            ovf_q <= 1'b0;
            eq_q <= 1'b0;
            acc_q <= '0;
            k_q <= '0;
            for (int i = 0; i < 4; i++) begin
              rq_q[i] <= hq_q[i];
            end
            rv_q[0] <= in_i.vec_x;
            rv_q[1] <= in_i.vec_y;
            rv_q[2] <= in_i.vec_z;
            rneg_q <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              ra_q[i] <= (in_i.opcode == qpu_pkg::OP_ROTATE) ? 32'sd0 : ht_q[i];
            end
            unique case (in_i.opcode)
              qpu_pkg::OP_LOAD: begin
                hq_q[0] <= in_i.quat_x;
                hq_q[1] <= in_i.quat_y;
                hq_q[2] <= in_i.quat_z;
                hq_q[3] <= in_i.quat_w;
                ht_q[0] <= in_i.vec_x;
                ht_q[1] <= in_i.vec_y;
                ht_q[2] <= in_i.vec_z;
                st_q <= S_DONE;
              end
              qpu_pkg::OP_COMPOSE: begin
                ph_q <= qpu_pkg::PH_QMUL;
                st_q <= S_MUL;
              end
              qpu_pkg::OP_XFORM, qpu_pkg::OP_ROTATE: begin
                ph_q <= qpu_pkg::PH_MAT;
                st_q <= S_MUL;
              end
              qpu_pkg::OP_INVERT: begin
                ph_q <= qpu_pkg::PH_NORM;
                st_q <= S_MUL;
              end
              qpu_pkg::OP_COMPARE: begin
                eq_q <= (hq_q[0] == in_i.quat_x) && (hq_q[1] == in_i.quat_y) &&
                        (hq_q[2] == in_i.quat_z) && (hq_q[3] == in_i.quat_w) &&
                        (ht_q[0] == in_i.vec_x) && (ht_q[1] == in_i.vec_y) &&
                        (ht_q[2] == in_i.vec_z);
                st_q <= S_DONE;
              end
              default: begin
                st_q <= S_DONE;
              end
            endcase
          end
        end
        S_MUL: begin
          p_q <= 64'(a_op) * 64'(b_op);
          cu_q <= uop;
          st_q <= S_ACC;
        end
        S_ACC: begin
          acc_q <= acc_n;
          k_q <= k_q + 5'd1;
          st_q <= cu_q.last ? S_FIN : S_MUL;
        end
        S_FIN: begin
          acc_q <= '0;
          unique case (ph_q)
            qpu_pkg::PH_QMUL: begin
              wq_q[cu_q.dst[1:0]] <= fsat;
              ovf_q <= ovf_q | fovf;
            end
            qpu_pkg::PH_MAT: begin
              m_q[cu_q.dst] <= fsat;
              ovf_q <= ovf_q | fovf;
            end
            qpu_pkg::PH_ROW: begin
              res_q[cu_q.dst[1:0]] <= fsat;
              ovf_q <= ovf_q | fovf;
            end
            default: begin
              d_q <= rnd;
            end
          endcase
          if (k_q == qpu_pkg::f_len(ph_q)) begin
            k_q <= '0;
            unique case (ph_q)
              qpu_pkg::PH_QMUL: begin
                ph_q <= qpu_pkg::PH_MAT;
                st_q <= S_MUL;
              end
              qpu_pkg::PH_MAT: begin
                ph_q <= qpu_pkg::PH_ROW;
                st_q <= S_MUL;
              end
              qpu_pkg::PH_ROW: begin
                cm_q <= (op_q == qpu_pkg::OP_COMPOSE) || (op_q == qpu_pkg::OP_INVERT);
                st_q <= S_DONE;
              end
              default: begin
                if (rnd <= 64'sd0) begin
                  ovf_q <= 1'b1;
                  st_q <= S_DONE;
                end else begin
                  di_q <= '0;
                  st_q <= S_DIV;
                end
              end
            endcase
          end else begin
            st_q <= S_MUL;
          end
        end
        S_DIV: begin
          if (div_done) begin
            wq_q[di_q] <= qsat;
            ovf_q <= ovf_q | qovf;
            if (di_q == 2'd3) begin
              for (int i = 0; i < 3; i++) begin
                rq_q[i] <= wq_q[i];
                rv_q[i] <= ht_q[i];
                ra_q[i] <= '0;
              end
              rq_q[3] <= qsat;
              rneg_q <= 1'b1;
              ph_q <= qpu_pkg::PH_MAT;
              k_q <= '0;
              st_q <= S_MUL;
            end else begin
              di_q <= di_q + 2'd1;
            end
          end
        end
        S_DONE: begin
          if (cm_q) begin
            cm_q <= 1'b0;
            for (int i = 0; i < 4; i++) begin
              hq_q[i] <= wq_q[i];
            end
            for (int i = 0; i < 3; i++) begin
              ht_q[i] <= res_q[i];
            end
          end
          if (out_free) begin
            oeq_q <= eq_q;
            oovf_q <= ovf_q;
            if (vec_res) begin
              ow_q <= '0;
              oqx_q <= '0;
              oqy_q <= '0;
              oqz_q <= '0;
              ox_q <= res_q[0];
              oy_q <= res_q[1];
              oz_q <= res_q[2];
            end else if (cm_q) begin
              ow_q <= wq_q[3];
              oqx_q <= wq_q[0];
              oqy_q <= wq_q[1];
              oqz_q <= wq_q[2];
              ox_q <= res_q[0];
              oy_q <= res_q[1];
              oz_q <= res_q[2];
            end else begin
              ow_q <= hq_q[3];
              oqx_q <= hq_q[0];
              oqy_q <= hq_q[1];
              oqz_q <= hq_q[2];
              ox_q <= ht_q[0];
              oy_q <= ht_q[1];
              oz_q <= ht_q[2];
            end
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready = (st_q == S_IDLE);
  assign out_o.valid = ov_q;
  assign out_o.out_w = ow_q;
  assign out_o.out_qx = oqx_q;
  assign out_o.out_qy = oqy_q;
  assign out_o.out_qz = oqz_q;
  assign out_o.out_x = ox_q;
  assign out_o.out_y = oy_q;
  assign out_o.out_z = oz_q;
  assign out_o.equal_flag = oeq_q;
  assign out_o.overflow_flag = oovf_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (st_q != S_IDLE))
    else $error("accepted word did not start processing");

  a_div_den_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DIV) |-> (!d_q[63] && (d_q != 64'sd0)))
    else $error("divider started with a non-positive norm");

  a_equal_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.equal_flag) |-> !out_o.overflow_flag)
    else $error("compare result flagged overflow");

  a_term_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_FIN) |-> (k_q <= qpu_pkg::f_len(ph_q)))
    else $error("term counter ran past its phase");
`endif

endmodule

`default_nettype wire
